// ===== rtl/core/nmea_rmc_field_parser_top_macros.svh =====
// Assertion helpers for the checker file.
`ifndef NMEA_RMC_FIELD_PARSER_TOP_MACROS_SVH
`define NMEA_RMC_FIELD_PARSER_TOP_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define NRMC_CHECK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled request keeps its payload on the next cycle.
`define NRMC_CHECK_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  `NRMC_CHECK(lbl, clk, rst_n, (vld && !rdy) |=> $stable(sig), msg)

`endif

// ===== rtl/core/nrmc_pkg.sv =====
`timescale 1ns / 1ps

package nrmc_pkg;

  localparam int unsigned OFFSET_W = 5;
  localparam logic [OFFSET_W-1:0] HOUR_OFFSET_RST = 5'd8;

  // Sentence contents captured at the closing byte.
  typedef struct packed {
    logic [31:0] time_accum;
    logic        time_reached;
    logic        fix_valid;
    logic [31:0] lat_digits;
    logic [7:0]  lat_hemisphere;
    logic [31:0] lon_digits;
    logic [7:0]  lon_hemisphere;
    logic        ended_by_zero;
  } snap_t;

  typedef struct packed {
    logic [7:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        fix_valid;
    logic [31:0] lat_digits;
    logic [7:0]  lat_hemisphere;
    logic [31:0] lon_digits;
    logic [7:0]  lon_hemisphere;
    logic        ended_by_zero;
  } res_t;

endpackage

// ===== rtl/core/nrmc_if.sv =====
`timescale 1ns / 1ps

interface nrmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic        fix_valid;
  logic [31:0] lat_digits;
  logic [7:0]  lat_hemisphere;
  logic [31:0] lon_digits;
  logic [7:0]  lon_hemisphere;
  logic        ended_by_zero;

  modport source (
    output valid, output hour, output minute, output second, output fix_valid,
    output lat_digits, output lat_hemisphere, output lon_digits,
    output lon_hemisphere, output ended_by_zero, input ready
  );
  modport sink (
    input valid, input hour, input minute, input second, input fix_valid,
    input lat_digits, input lat_hemisphere, input lon_digits,
    input lon_hemisphere, input ended_by_zero, output ready
  );
endinterface

// ===== rtl/core/nmea_rmc_field_parser_top.sv =====
`timescale 1ns / 1ps

// RMC sentence parser: takes one received byte per cycle while in_if.ready is
// high, finds a $GPRMC or $GNRMC header and reports time, status, latitude,
// longitude and hemisphere characters once per sentence, at its twelfth comma
// or at a zero byte. The sentence state updates in the same cycle a byte is
// taken. The report leaves the output register after a four-stage result
// pipeline that splits the time value into hour, minute and second with two
// reciprocal multiplies by 1/100. Input stalls only when all four result
// stages hold reports and the output is not taken. cfg_data (hour offset,
// reset 8) is written by cfg_we and should be changed only while no report
// is in flight. Position fields not reached keep the values of the previous
// sentence.

module nmea_rmc_field_parser_top import nrmc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [OFFSET_W-1:0] cfg_data,
  nrmc_in_if.sink             in_if,
  nrmc_out_if.source          out_if
);

  logic  in_ready;
  logic  in_fire;
  logic  emit;
  snap_t snap;
  res_t  res;

  assign in_fire     = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  nrmc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_if.rx_byte),
    .emit    (emit),
    .snap    (snap)
  );

  nrmc_time_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .snap_valid (emit),
    .snap       (snap),
    .snap_ready (in_ready),
    .res_valid  (out_if.valid),
    .res_ready  (out_if.ready),
    .res        (res)
  );

  assign out_if.hour           = res.hour;
  assign out_if.minute         = res.minute;
  assign out_if.second         = res.second;
  assign out_if.fix_valid      = res.fix_valid;
  assign out_if.lat_digits     = res.lat_digits;
  assign out_if.lat_hemisphere = res.lat_hemisphere;
  assign out_if.lon_digits     = res.lon_digits;
  assign out_if.lon_hemisphere = res.lon_hemisphere;
  assign out_if.ended_by_zero  = res.ended_by_zero;

endmodule

// ===== rtl/core/nrmc_parser.sv =====
`timescale 1ns / 1ps

module nrmc_parser import nrmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  output logic       emit,
  output snap_t      snap
);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;

  localparam logic [2:0] HDR_LEN = 3'd6;

  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_LAT_NS = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_LON_EW = 4'd6;
  localparam logic [3:0] LAST_COMMA = 4'd12;

  function automatic logic hdr_match(input logic [2:0] pos, input logic [7:0] b);
    logic m;
    m = 1'b0;
    case (pos)
      3'd0:    m = (b == CH_DOLLAR);
      3'd1:    m = (b == CH_G);
      3'd2:    m = (b == CH_N) || (b == CH_P);
      3'd3:    m = (b == CH_R);
      3'd4:    m = (b == CH_M);
      3'd5:    m = (b == CH_C);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] digit_acc(input logic [31:0] acc, input logic [7:0] b);
    return {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {24'd0, b} - {24'd0, CH_ZERO};
  endfunction

  logic [2:0]  hdr_r, hdr_nxt;
  logic        in_sent_r, in_sent_nxt;
  logic [3:0]  comma_r, comma_nxt;
  logic        fstart_r, fstart_nxt;
  logic        tstop_r, tstop_nxt;
  logic [31:0] time_r, time_nxt;
  logic        status_r, status_nxt;
  logic [31:0] lat_r, lat_nxt;
  logic [31:0] lon_r, lon_nxt;
  logic [7:0]  latc_r, latc_nxt;
  logic [7:0]  lonc_r, lonc_nxt;
  logic        emit_c;
  logic        by_zero_c;
  logic [3:0]  comma_inc;

  assign comma_inc = comma_r + 4'd1;

  always_comb begin
    hdr_nxt     = hdr_r;
    in_sent_nxt = in_sent_r;
    comma_nxt   = comma_r;
    fstart_nxt  = fstart_r;
    tstop_nxt   = tstop_r;
    time_nxt    = time_r;
    status_nxt  = status_r;
    lat_nxt     = lat_r;
    lon_nxt     = lon_r;
    latc_nxt    = latc_r;
    lonc_nxt    = lonc_r;
    emit_c      = 1'b0;
    by_zero_c   = 1'b0;
    if (!in_sent_r) begin
      if (hdr_match(hdr_r, rx_byte)) begin
        hdr_nxt = hdr_r + 3'd1;
      end else begin
        hdr_nxt = (rx_byte == CH_DOLLAR) ? 3'd1 : 3'd0;
      end
      if (hdr_nxt == HDR_LEN) begin
        hdr_nxt     = 3'd0;
        in_sent_nxt = 1'b1;
        comma_nxt   = 4'd0;
        fstart_nxt  = 1'b0;
        tstop_nxt   = 1'b0;
        time_nxt    = 32'd0;
        status_nxt  = 1'b0;
      end
    end else begin
      // first byte of a one-character field is taken whatever it is
      if (fstart_r) begin
        case (comma_r)
          FLD_STATUS: status_nxt = (rx_byte == CH_A);
          FLD_LAT_NS: latc_nxt = rx_byte;
          FLD_LON_EW: lonc_nxt = rx_byte;
          default:    ;
        endcase
        fstart_nxt = 1'b0;
      end
      if (rx_byte == CH_NUL) begin
        emit_c      = 1'b1;
        by_zero_c   = 1'b1;
        in_sent_nxt = 1'b0;
        hdr_nxt     = 3'd0;
        fstart_nxt  = 1'b0;
      end else if (rx_byte == CH_COMMA) begin
        comma_nxt = comma_inc;
        case (comma_inc)
          FLD_TIME: begin
            time_nxt  = 32'd0;
            tstop_nxt = 1'b0;
          end
          FLD_STATUS, FLD_LAT_NS, FLD_LON_EW: fstart_nxt = 1'b1;
          FLD_LAT: lat_nxt = 32'd0;
          FLD_LON: lon_nxt = 32'd0;
          default: ;
        endcase
        if (comma_inc >= LAST_COMMA) begin
          emit_c      = 1'b1;
          in_sent_nxt = 1'b0;
          hdr_nxt     = 3'd0;
          fstart_nxt  = 1'b0;
        end
      end else if (comma_r == FLD_TIME && !tstop_r) begin
        if (rx_byte == CH_DOT) begin
          tstop_nxt = 1'b1;
        end else begin
          time_nxt = digit_acc(time_r, rx_byte);
        end
      end else if (comma_r == FLD_LAT && rx_byte != CH_DOT) begin
        lat_nxt = digit_acc(lat_r, rx_byte);
      end else if (comma_r == FLD_LON && rx_byte != CH_DOT) begin
        lon_nxt = digit_acc(lon_r, rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= 3'd0;
      in_sent_r <= 1'b0;
      comma_r   <= 4'd0;
      fstart_r  <= 1'b0;
      tstop_r   <= 1'b0;
      time_r    <= 32'd0;
      status_r  <= 1'b0;
      lat_r     <= 32'd0;
      lon_r     <= 32'd0;
      latc_r    <= 8'd0;
      lonc_r    <= 8'd0;
    end else if (in_fire) begin
      hdr_r     <= hdr_nxt;
      in_sent_r <= in_sent_nxt;
      comma_r   <= comma_nxt;
      fstart_r  <= fstart_nxt;
      tstop_r   <= tstop_nxt;
      time_r    <= time_nxt;
      status_r  <= status_nxt;
      lat_r     <= lat_nxt;
      lon_r     <= lon_nxt;
      latc_r    <= latc_nxt;
      lonc_r    <= lonc_nxt;
    end
  end

  assign emit = in_fire && emit_c;

  always_comb begin
    snap.time_accum     = time_nxt;
    snap.time_reached   = (comma_nxt != 4'd0);
    snap.fix_valid      = status_nxt;
    snap.lat_digits     = lat_nxt;
    snap.lat_hemisphere = latc_nxt;
    snap.lon_digits     = lon_nxt;
    snap.lon_hemisphere = lonc_nxt;
    snap.ended_by_zero  = by_zero_c;
  end

endmodule

// ===== rtl/core/nrmc_time_split.sv =====
`timescale 1ns / 1ps

module nrmc_time_split import nrmc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [OFFSET_W-1:0] cfg_data,
  input  logic                snap_valid,
  input  snap_t               snap,
  output logic                snap_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res
);

  // floor(x / 100) == (x * DIV100_MAGIC) >> 37 for every 32-bit x
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam logic [6:0]  HUNDRED      = 7'd100;
  localparam logic [7:0]  DAY_HOURS    = 8'd24;

  logic [OFFSET_W-1:0] off_r;
  logic                v0_r, v1_r, v2_r, v3_r;
  logic                en0, en1, en2, en3;

  snap_t       s0_r, s1_r, s2_r;
  logic [25:0] q1_r, q1b_r;
  logic [18:0] q2_r;
  logic [6:0]  sec_r;
  res_t        res_r;

  logic [63:0] prod1;
  logic [63:0] prod2;
  logic [6:0]  q1_x100;
  logic [6:0]  q2_x100;
  logic [6:0]  sec_c;
  logic [6:0]  min_c;
  logic [7:0]  hsum;
  logic [7:0]  hour_c;

  // advance a stage when the one after it can take its contents
  assign en3        = !v3_r || res_ready;
  assign en2        = !v2_r || en3;
  assign en1        = !v1_r || en2;
  assign en0        = !v0_r || en1;
  assign snap_ready = en0;

  assign prod1   = {32'd0, s0_r.time_accum} * {32'd0, DIV100_MAGIC};
  assign prod2   = {38'd0, q1_r} * {32'd0, DIV100_MAGIC};
  assign q1_x100 = 7'(q1_r[6:0] * HUNDRED);
  assign sec_c   = s1_r.time_accum[6:0] - q1_x100;
  assign q2_x100 = 7'(q2_r[6:0] * HUNDRED);
  assign min_c   = q1b_r[6:0] - q2_x100;
  assign hsum    = q2_r[7:0] + {{(8-OFFSET_W){1'b0}}, off_r};
  assign hour_c  = (hsum >= DAY_HOURS) ? (hsum - DAY_HOURS) : hsum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= HOUR_OFFSET_RST;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        off_r <= cfg_data;
      end
      if (en0) v0_r <= snap_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_r <= snap;
    end
    if (en1) begin
      s1_r <= s0_r;
      q1_r <= prod1[62:37];
    end
    if (en2) begin
      s2_r  <= s1_r;
      q1b_r <= q1_r;
      q2_r  <= prod2[55:37];
      sec_r <= sec_c;
    end
    if (en3) begin
      res_r.hour           <= s2_r.time_reached ? hour_c : 8'd0;
      res_r.minute         <= s2_r.time_reached ? min_c : 7'd0;
      res_r.second         <= s2_r.time_reached ? sec_r : 7'd0;
      res_r.fix_valid      <= s2_r.fix_valid;
      res_r.lat_digits     <= s2_r.lat_digits;
      res_r.lat_hemisphere <= s2_r.lat_hemisphere;
      res_r.lon_digits     <= s2_r.lon_digits;
      res_r.lon_hemisphere <= s2_r.lon_hemisphere;
      res_r.ended_by_zero  <= s2_r.ended_by_zero;
    end
  end

  assign res_valid = v3_r;
  assign res       = res_r;

endmodule

// ===== rtl/core/nrmc_checker.sv =====
`timescale 1ns / 1ps

`include "nmea_rmc_field_parser_top_macros.svh"

module nrmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  hour,
  input logic [6:0]  minute,
  input logic [6:0]  second,
  input logic        fix_valid,
  input logic [31:0] lat_digits,
  input logic [7:0]  lat_hemisphere,
  input logic [31:0] lon_digits,
  input logic [7:0]  lon_hemisphere,
  input logic        ended_by_zero
);

  logic [103:0] out_payload;
  logic         min_ok;
  logic         sec_ok;

  assign out_payload = {hour, minute, second, fix_valid, lat_digits, lat_hemisphere,
                        lon_digits, lon_hemisphere, ended_by_zero};
  assign min_ok = (minute <= 7'd99);
  assign sec_ok = (second <= 7'd99);

  `NRMC_CHECK_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, out_payload, "result changed while stalled")
  `NRMC_CHECK(a_time_range, clk, rst_n, out_valid |-> (min_ok && sec_ok), "minute or second above 99")
  `NRMC_CHECK(a_no_block, clk, rst_n, out_ready |-> in_ready, "input blocked while output drains")

endmodule

bind nmea_rmc_field_parser_top nrmc_checker u_nrmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .hour           (out_if.hour),
  .minute         (out_if.minute),
  .second         (out_if.second),
  .fix_valid      (out_if.fix_valid),
  .lat_digits     (out_if.lat_digits),
  .lat_hemisphere (out_if.lat_hemisphere),
  .lon_digits     (out_if.lon_digits),
  .lon_hemisphere (out_if.lon_hemisphere),
  .ended_by_zero  (out_if.ended_by_zero)
);
